// ===== hdl/buddy_pkg.sv =====
// Shared types, constants and free map addressing for the buddy allocator.
package buddy_pkg;

  localparam int LEVELS          = 11;
  localparam int MIN_BLOCK_BYTES = 16;
  localparam int MIN_LOG         = $clog2(MIN_BLOCK_BYTES);
  localparam int LVL_W           = 4;
  localparam int POS_W           = LEVELS - 1;
  localparam int LEAF_COUNT      = 1 << POS_W;
  localparam int SIZE_W          = 15;
  localparam int OFF_W           = 14;

  localparam logic [LVL_W-1:0] TOP_MAX    = LVL_W'(LEVELS - 1);
  localparam logic [LVL_W-1:0] POOL_RESET = LVL_W'(10);

  // Free map: one row of bits per level, packed into 32-bit words.
  localparam int WORD_BITS = 32;
  localparam int WORD_LOG  = $clog2(WORD_BITS);
  localparam int WIDX_W    = POS_W - WORD_LOG;
  localparam int ROW_SPLIT = (POS_W > WORD_LOG) ? POS_W - WORD_LOG : 0;
  localparam int ROW_SPAN  = 2 << ROW_SPLIT;
  localparam int FM_WORDS  = ROW_SPAN - 2 + LEVELS - ROW_SPLIT;
  localparam int FM_AW     = $clog2(FM_WORDS);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } buddy_op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } buddy_status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_A_RD,
    S_A_TEST,
    S_SP_RD,
    S_SP_WR,
    S_A_FIN,
    S_F_TEST,
    S_M_RD,
    S_M_WR
  } buddy_state_e;

  typedef struct packed {
    buddy_op_e               op;
    logic [SIZE_W-1:0]       size_bytes;
    logic [OFF_W-1:0]        free_offset;
  } buddy_req_t;

  typedef struct packed {
    buddy_status_e           status;
    logic [OFF_W-1:0]        alloc_offset;
  } buddy_rsp_t;

  // Command from the sequencer to the free map.
  typedef struct packed {
    logic                    rd;
    logic [LVL_W-1:0]        rd_lvl;
    logic [POS_W-1:0]        rd_pos;
    logic                    wr;
    logic [LVL_W-1:0]        wr_lvl;
    logic [POS_W-1:0]        wr_pos;
    logic [WORD_BITS-1:0]    wdata;
    logic                    clr;
    logic [FM_AW-1:0]        clr_addr;
    logic [LVL_W-1:0]        top;
  } buddy_fm_cmd_t;

  // First word of a level's row.
  function automatic logic [FM_AW-1:0] fm_base(logic [LVL_W-1:0] lvl);
    logic [FM_AW-1:0] base;
    if (lvl <= LVL_W'(ROW_SPLIT)) begin
      base = FM_AW'(ROW_SPAN) - (FM_AW'(ROW_SPAN) >> lvl);
    end else begin
      base = FM_AW'(ROW_SPAN - 2 - ROW_SPLIT) + FM_AW'(lvl);
    end
    return base;
  endfunction

  // Word holding node (lvl, pos).
  function automatic logic [FM_AW-1:0] fm_addr(logic [LVL_W-1:0] lvl,
                                               logic [POS_W-1:0] pos);
    return fm_base(lvl) + FM_AW'(pos[POS_W-1:WORD_LOG]);
  endfunction

endpackage

// ===== hdl/buddy_free_map.sv =====
// Free map memory: per-level free bits in words, with first-free search.
module buddy_free_map (
  input  logic                             clk_i,
  input  buddy_pkg::buddy_fm_cmd_t         cmd_i,
  output logic [buddy_pkg::WORD_BITS-1:0]  rdata_o,
  output logic                             nz_o,
  output logic [buddy_pkg::WORD_LOG-1:0]   first_o
);

  logic [buddy_pkg::WORD_BITS-1:0] mem [buddy_pkg::FM_WORDS];
  logic [buddy_pkg::WORD_BITS-1:0] rdata_q;
  logic [buddy_pkg::FM_AW-1:0]     raddr;
  logic [buddy_pkg::FM_AW-1:0]     waddr;
  logic [buddy_pkg::WORD_BITS-1:0] wdata;
  logic                            wen;

  always_comb begin
    raddr = buddy_pkg::fm_addr(cmd_i.rd_lvl, cmd_i.rd_pos);
    wen   = cmd_i.wr || cmd_i.clr;
    if (cmd_i.clr) begin
      // Sweep: only the pool root survives.
      waddr = cmd_i.clr_addr;
      wdata = (cmd_i.clr_addr == buddy_pkg::fm_base(cmd_i.top)) ?
              buddy_pkg::WORD_BITS'(1) : '0;
    end else begin
      waddr = buddy_pkg::fm_addr(cmd_i.wr_lvl, cmd_i.wr_pos);
      wdata = cmd_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[raddr];
    end
  end

  // Lowest set bit of the word just read.
  always_comb begin
    first_o = '0;
    for (int i = buddy_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (rdata_q[i]) begin
        first_o = buddy_pkg::WORD_LOG'(i);
      end
    end
  end

  assign nz_o    = |rdata_q;
  assign rdata_o = rdata_q;

endmodule

// ===== hdl/buddy_allocator.sv =====
// Binary buddy allocator top level: sequencer, allocation table and result register.
// Allocate: read and test free map words from the wanted level upward, then split
//   down to it; pool full returns ST_FULL, zero or oversized size ST_BAD.
// Free: merge buddies upward; bad offset or no allocated block there gives ST_BAD.
// One item at a time. Reset and each cfg_we_i pool write start a clearing
//   pass with busy high; done_o strobes each result for one cycle, no stall.
module buddy_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  buddy_pkg::buddy_req_t         req_i,
  output logic                          done_o,
  output buddy_pkg::buddy_rsp_t         rsp_o,
  input  logic                          cfg_we_i,
  input  logic [buddy_pkg::LVL_W-1:0]   cfg_wdata_i
);

  // Allocation table entry: start mark and block level per minimum block.
  typedef struct packed {
    logic                          mark;
    logic [buddy_pkg::LVL_W-1:0]   level;
  } at_entry_t;

  buddy_pkg::buddy_state_e          state_q, state_d;
  logic [buddy_pkg::LVL_W-1:0]      pool_q, pool_d;
  logic [buddy_pkg::POS_W-1:0]      cnt_q, cnt_d;
  logic                             done_q, done_d;
  buddy_pkg::buddy_req_t            req_q, req_d;
  buddy_pkg::buddy_rsp_t            rsp_q, rsp_d;
  logic [buddy_pkg::LVL_W-1:0]      lvl_q, lvl_d;
  logic [buddy_pkg::LVL_W-1:0]      want_q, want_d;
  logic [buddy_pkg::POS_W-1:0]      pos_q, pos_d;
  logic [buddy_pkg::POS_W-1:0]      leaf_q, leaf_d;

  // Free map port.
  buddy_pkg::buddy_fm_cmd_t         fm_cmd;
  logic [buddy_pkg::WORD_BITS-1:0]  fm_rdata;
  logic                             fm_nz;
  logic [buddy_pkg::WORD_LOG-1:0]   fm_first;

  // Allocation table memory.
  at_entry_t                        at_mem [buddy_pkg::LEAF_COUNT];
  at_entry_t                        at_rdata_q;
  logic                             at_rd;
  logic                             at_wr;
  logic [buddy_pkg::POS_W-1:0]      at_waddr;
  at_entry_t                        at_wdata;

  // Decoded request and loop conditions.
  logic [buddy_pkg::LVL_W-1:0]      top;
  logic [buddy_pkg::SIZE_W-1:0]     pool_bytes;
  logic [buddy_pkg::SIZE_W-1:0]     size_m1;
  logic [buddy_pkg::POS_W-1:0]      size_blocks;
  logic [buddy_pkg::LVL_W-1:0]      want_c;
  logic                             alloc_bad;
  logic [buddy_pkg::POS_W-1:0]      free_leaf;
  logic                             free_bad;
  logic [buddy_pkg::LVL_W-1:0]      span;
  logic [buddy_pkg::WIDX_W-1:0]     last_widx;
  logic                             last_word;
  logic [buddy_pkg::POS_W-1:0]      found_pos;
  logic [buddy_pkg::WORD_LOG-1:0]   bud_idx;
  logic                             merge_go;
  logic [buddy_pkg::LVL_W-1:0]      free_lvl;
  logic [buddy_pkg::POS_W-1:0]      a_leaf;
  logic                             clr_last;

  buddy_free_map u_free_map (
    .clk_i   (clk_i),
    .cmd_i   (fm_cmd),
    .rdata_o (fm_rdata),
    .nz_o    (fm_nz),
    .first_o (fm_first)
  );

  // Saturate the pool setting to the tree height.
  assign top = (pool_q > buddy_pkg::TOP_MAX) ? buddy_pkg::TOP_MAX : pool_q;

  // Allocate decode: reject zero and oversized, round up to a level.
  always_comb begin
    pool_bytes  = buddy_pkg::SIZE_W'(buddy_pkg::MIN_BLOCK_BYTES) << top;
    alloc_bad   = (req_q.size_bytes == '0) || (req_q.size_bytes > pool_bytes);
    size_m1     = req_q.size_bytes - buddy_pkg::SIZE_W'(1);
    size_blocks = size_m1[buddy_pkg::MIN_LOG +: buddy_pkg::POS_W];
    want_c      = '0;
    for (int i = 0; i < buddy_pkg::POS_W; i++) begin
      if (size_blocks[i]) begin
        want_c = buddy_pkg::LVL_W'(i + 1);
      end
    end
  end

  // Free decode: offset must be block aligned and inside the pool.
  assign free_leaf = req_q.free_offset[buddy_pkg::MIN_LOG +: buddy_pkg::POS_W];
  assign free_bad  = (req_q.free_offset[buddy_pkg::MIN_LOG-1:0] != '0) ||
                     ((free_leaf >> top) != '0);

  // Last word of the current level's row under the pool top.
  always_comb begin
    span      = top - lvl_q;
    last_widx = '0;
    if (span > buddy_pkg::LVL_W'(buddy_pkg::WORD_LOG)) begin
      last_widx = buddy_pkg::WIDX_W'((1 << (span - buddy_pkg::LVL_W'(buddy_pkg::WORD_LOG))) - 1);
    end
    last_word = (pos_q[buddy_pkg::POS_W-1:buddy_pkg::WORD_LOG] == last_widx);
  end

  assign found_pos = {pos_q[buddy_pkg::POS_W-1:buddy_pkg::WORD_LOG], fm_first};
  assign bud_idx   = pos_q[buddy_pkg::WORD_LOG-1:0] ^ buddy_pkg::WORD_LOG'(1);
  assign merge_go  = (lvl_q < top) && fm_rdata[bud_idx];
  assign free_lvl  = (at_rdata_q.level > top) ? top : at_rdata_q.level;
  assign a_leaf    = pos_q << want_q;
  assign clr_last  = (cnt_q == buddy_pkg::POS_W'(buddy_pkg::LEAF_COUNT - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      buddy_pkg::S_CLEAR: begin
        if (clr_last) state_d = buddy_pkg::S_IDLE;
      end
      buddy_pkg::S_IDLE: begin
        if (start) state_d = buddy_pkg::S_CHECK;
      end
      buddy_pkg::S_CHECK: begin
        if (req_q.op == buddy_pkg::OP_ALLOC) begin
          state_d = alloc_bad ? buddy_pkg::S_IDLE : buddy_pkg::S_A_RD;
        end else begin
          state_d = free_bad ? buddy_pkg::S_IDLE : buddy_pkg::S_F_TEST;
        end
      end
      buddy_pkg::S_A_RD: begin
        state_d = buddy_pkg::S_A_TEST;
      end
      buddy_pkg::S_A_TEST: begin
        if (fm_nz) begin
          state_d = (lvl_q == want_q) ? buddy_pkg::S_A_FIN : buddy_pkg::S_SP_RD;
        end else if (last_word && lvl_q == top) begin
          state_d = buddy_pkg::S_IDLE;
        end else begin
          state_d = buddy_pkg::S_A_RD;
        end
      end
      buddy_pkg::S_SP_RD: begin
        state_d = buddy_pkg::S_SP_WR;
      end
      buddy_pkg::S_SP_WR: begin
        state_d = (lvl_q == want_q) ? buddy_pkg::S_A_FIN : buddy_pkg::S_SP_RD;
      end
      buddy_pkg::S_A_FIN: begin
        state_d = buddy_pkg::S_IDLE;
      end
      buddy_pkg::S_F_TEST: begin
        state_d = at_rdata_q.mark ? buddy_pkg::S_M_RD : buddy_pkg::S_IDLE;
      end
      buddy_pkg::S_M_RD: begin
        state_d = buddy_pkg::S_M_WR;
      end
      buddy_pkg::S_M_WR: begin
        state_d = merge_go ? buddy_pkg::S_M_RD : buddy_pkg::S_IDLE;
      end
      default: begin
        state_d = buddy_pkg::S_CLEAR;
      end
    endcase
    // A pool write empties the pool: restart the sweep.
    if (cfg_we_i) state_d = buddy_pkg::S_CLEAR;
  end

  // Datapath and memory controls.
  always_comb begin
    pool_d   = pool_q;
    cnt_d    = cnt_q;
    req_d    = req_q;
    lvl_d    = lvl_q;
    want_d   = want_q;
    pos_d    = pos_q;
    leaf_d   = leaf_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;

    fm_cmd          = '0;
    fm_cmd.top      = top;
    fm_cmd.clr_addr = cnt_q[buddy_pkg::FM_AW-1:0];

    at_rd    = 1'b0;
    at_wr    = 1'b0;
    at_waddr = leaf_q;
    at_wdata = '0;

    case (state_q)
      buddy_pkg::S_CLEAR: begin
        // Sweep both memories; the free map is much shorter.
        fm_cmd.clr = (cnt_q < buddy_pkg::POS_W'(buddy_pkg::FM_WORDS));
        at_wr      = 1'b1;
        at_waddr   = cnt_q;
        cnt_d      = cnt_q + buddy_pkg::POS_W'(1);
      end
      buddy_pkg::S_IDLE: begin
        if (start) req_d = req_i;
      end
      buddy_pkg::S_CHECK: begin
        if (req_q.op == buddy_pkg::OP_ALLOC) begin
          if (alloc_bad) begin
            done_d             = 1'b1;
            rsp_d.status       = buddy_pkg::ST_BAD;
            rsp_d.alloc_offset = '0;
          end else begin
            want_d = want_c;
            lvl_d  = want_c;
            pos_d  = '0;
          end
        end else begin
          if (free_bad) begin
            done_d             = 1'b1;
            rsp_d.status       = buddy_pkg::ST_BAD;
            rsp_d.alloc_offset = '0;
          end else begin
            at_rd  = 1'b1;
            leaf_d = free_leaf;
          end
        end
      end
      buddy_pkg::S_A_RD: begin
        fm_cmd.rd     = 1'b1;
        fm_cmd.rd_lvl = lvl_q;
        fm_cmd.rd_pos = pos_q;
      end
      buddy_pkg::S_A_TEST: begin
        if (fm_nz) begin
          // Take the lowest free block of this level.
          fm_cmd.wr     = 1'b1;
          fm_cmd.wr_lvl = lvl_q;
          fm_cmd.wr_pos = found_pos;
          fm_cmd.wdata  = fm_rdata & ~(buddy_pkg::WORD_BITS'(1) << fm_first);
          pos_d         = found_pos;
        end else if (last_word) begin
          if (lvl_q == top) begin
            done_d             = 1'b1;
            rsp_d.status       = buddy_pkg::ST_FULL;
            rsp_d.alloc_offset = '0;
          end else begin
            lvl_d = lvl_q + buddy_pkg::LVL_W'(1);
            pos_d = '0;
          end
        end else begin
          pos_d = pos_q + buddy_pkg::POS_W'(buddy_pkg::WORD_BITS);
        end
      end
      buddy_pkg::S_SP_RD: begin
        // Descend one level; the upper half becomes free.
        lvl_d         = lvl_q - buddy_pkg::LVL_W'(1);
        pos_d         = pos_q << 1;
        fm_cmd.rd     = 1'b1;
        fm_cmd.rd_lvl = lvl_q - buddy_pkg::LVL_W'(1);
        fm_cmd.rd_pos = (pos_q << 1) | buddy_pkg::POS_W'(1);
      end
      buddy_pkg::S_SP_WR: begin
        fm_cmd.wr     = 1'b1;
        fm_cmd.wr_lvl = lvl_q;
        fm_cmd.wr_pos = pos_q | buddy_pkg::POS_W'(1);
        fm_cmd.wdata  = fm_rdata | (buddy_pkg::WORD_BITS'(1) <<
                        (pos_q[buddy_pkg::WORD_LOG-1:0] | buddy_pkg::WORD_LOG'(1)));
      end
      buddy_pkg::S_A_FIN: begin
        at_wr              = 1'b1;
        at_waddr           = a_leaf;
        at_wdata.mark      = 1'b1;
        at_wdata.level     = want_q;
        done_d             = 1'b1;
        rsp_d.status       = buddy_pkg::ST_OK;
        rsp_d.alloc_offset = {a_leaf, {buddy_pkg::MIN_LOG{1'b0}}};
      end
      buddy_pkg::S_F_TEST: begin
        if (!at_rdata_q.mark) begin
          done_d             = 1'b1;
          rsp_d.status       = buddy_pkg::ST_BAD;
          rsp_d.alloc_offset = '0;
        end else begin
          // Drop the table entry and start merging from the block's level.
          at_wr = 1'b1;
          lvl_d = free_lvl;
          pos_d = leaf_q >> free_lvl;
        end
      end
      buddy_pkg::S_M_RD: begin
        fm_cmd.rd     = 1'b1;
        fm_cmd.rd_lvl = lvl_q;
        fm_cmd.rd_pos = pos_q;
      end
      buddy_pkg::S_M_WR: begin
        // Block and buddy share a word.
        fm_cmd.wr     = 1'b1;
        fm_cmd.wr_lvl = lvl_q;
        fm_cmd.wr_pos = pos_q;
        if (merge_go) begin
          fm_cmd.wdata = fm_rdata & ~(buddy_pkg::WORD_BITS'(1) << bud_idx);
          lvl_d        = lvl_q + buddy_pkg::LVL_W'(1);
          pos_d        = pos_q >> 1;
        end else begin
          fm_cmd.wdata = fm_rdata |
                         (buddy_pkg::WORD_BITS'(1) << pos_q[buddy_pkg::WORD_LOG-1:0]);
          done_d             = 1'b1;
          rsp_d.status       = buddy_pkg::ST_OK;
          rsp_d.alloc_offset = '0;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase

    if (cfg_we_i) begin
      pool_d = cfg_wdata_i;
      cnt_d  = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= buddy_pkg::S_CLEAR;
      pool_q  <= buddy_pkg::POOL_RESET;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pool_q  <= pool_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    rsp_q  <= rsp_d;
    lvl_q  <= lvl_d;
    want_q <= want_d;
    pos_q  <= pos_d;
    leaf_q <= leaf_d;
  end

  // Allocation table: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (at_wr) begin
      at_mem[at_waddr] <= at_wdata;
    end
    if (at_rd) begin
      at_rdata_q <= at_mem[free_leaf];
    end
  end

  assign busy   = (state_q != buddy_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== hdl/buddy_chk.sv =====
// Port-level checker for the buddy allocator, bound to the top level.
module buddy_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input buddy_pkg::buddy_req_t         req_i,
  input logic                          done_o,
  input buddy_pkg::buddy_rsp_t         rsp_o,
  input logic                          cfg_we_i,
  input logic [buddy_pkg::LVL_W-1:0]   cfg_wdata_i
);

  // A transfer occupies the block.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  // A result only follows work in progress.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without preceding work");

  // One strobe per item.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // Only a successful allocation carries an offset.
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != buddy_pkg::ST_OK) |-> (rsp_o.alloc_offset == '0))
    else $error("failed request returned a nonzero offset");

  // A pool write starts the clearing pass.
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (busy && !done_o))
    else $error("pool write did not start the clearing pass");

endmodule

bind buddy_allocator buddy_chk u_buddy_chk (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the buddy allocator: request driver, result monitor, pool model.
`timescale 1ns / 1ps

module testbench;

  localparam int NODE_COUNT = (1 << buddy_pkg::LEVELS) - 1;
  localparam int REQ_W      = $bits(buddy_pkg::buddy_req_t);
  localparam int POOL_MAX_B = buddy_pkg::MIN_BLOCK_BYTES << buddy_pkg::TOP_MAX;

  // Kinds of work the stimulus list carries. A live free picks its offset
  // from the allocated blocks at the moment it is driven.
  typedef enum logic [1:0] {
    K_REQ,
    K_FREE_LIVE,
    K_CFG,
    K_DRAIN
  } work_kind_e;

  typedef struct {
    work_kind_e                   kind;
    buddy_pkg::buddy_req_t        req;
    logic [buddy_pkg::LVL_W-1:0]  cfg;
  } work_item_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         start       = 1'b0;
  logic                         busy;
  buddy_pkg::buddy_req_t        req_i       = '0;
  logic                         done_o;
  buddy_pkg::buddy_rsp_t        rsp_o;
  logic                         cfg_we_i    = 1'b0;
  logic [buddy_pkg::LVL_W-1:0]  cfg_wdata_i = buddy_pkg::POOL_RESET;

  work_item_t            work_q[$];
  buddy_pkg::buddy_rsp_t rsp_pending[$];
  int                    live_offs[$];
  int                    n_bad    = 0;
  int                    n_sent   = 0;
  int                    hold_cnt = 0;
  int                    calm_cnt = 0;

  // Pool model: free mark per tree node, level and start mark per leaf.
  bit                           free_mark [NODE_COUNT];
  logic [buddy_pkg::LVL_W-1:0]  blk_level [buddy_pkg::LEAF_COUNT];
  bit                           blk_start [buddy_pkg::LEAF_COUNT];
  logic [buddy_pkg::LVL_W-1:0]  pool_cfg;

  buddy_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  task automatic flag_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    n_bad++;
  endtask

  function automatic int node_at(int lvl, int pos);
    return ((1 << (buddy_pkg::LEVELS - 1 - lvl)) - 1) + pos;
  endfunction

  // Pool settings above the tree height saturate to the top level.
  function automatic int pool_top();
    return (pool_cfg > buddy_pkg::TOP_MAX) ? int'(buddy_pkg::TOP_MAX) : int'(pool_cfg);
  endfunction

  // Empty the pool: forget every allocation and free only the new root.
  function automatic void pool_load(logic [buddy_pkg::LVL_W-1:0] v);
    pool_cfg = v;
    foreach (free_mark[i]) free_mark[i] = 1'b0;
    foreach (blk_start[i]) begin
      blk_start[i] = 1'b0;
      blk_level[i] = '0;
    end
    free_mark[node_at(pool_top(), 0)] = 1'b1;
    live_offs.delete();
  endfunction

  // Serve one request against the pool model and return its result.
  function automatic buddy_pkg::buddy_rsp_t buddy_serve(buddy_pkg::buddy_req_t rq);
    buddy_pkg::buddy_rsp_t r;
    int         top;
    int         want;
    int         lvl;
    int         pos;
    int         p;
    int         leaf;
    int         off;
    int         k;
    bit         found;
    top            = pool_top();
    r.status       = buddy_pkg::ST_OK;
    r.alloc_offset = '0;
    if (rq.op == buddy_pkg::OP_ALLOC) begin
      if (rq.size_bytes == 0 ||
          int'(rq.size_bytes) > (buddy_pkg::MIN_BLOCK_BYTES << top)) begin
        r.status = buddy_pkg::ST_BAD;
      end else begin
        want = 0;
        while (want < top && (buddy_pkg::MIN_BLOCK_BYTES << want) < int'(rq.size_bytes))
          want++;
        // Take the lowest free block at the smallest level that fits.
        found = 1'b0;
        pos   = 0;
        lvl   = want;
        while (!found && lvl <= top) begin
          for (p = 0; p < (1 << (top - lvl)); p++) begin
            if (!found && free_mark[node_at(lvl, p)]) begin
              pos   = p;
              found = 1'b1;
            end
          end
          if (!found) lvl++;
        end
        if (!found) begin
          r.status = buddy_pkg::ST_FULL;
        end else begin
          // Split down, leaving each upper half free.
          free_mark[node_at(lvl, pos)] = 1'b0;
          while (lvl > want) begin
            lvl--;
            pos = pos << 1;
            free_mark[node_at(lvl, pos + 1)] = 1'b1;
          end
          leaf            = pos << want;
          blk_start[leaf] = 1'b1;
          blk_level[leaf] = buddy_pkg::LVL_W'(want);
          r.alloc_offset  = buddy_pkg::OFF_W'(leaf * buddy_pkg::MIN_BLOCK_BYTES);
          live_offs.push_back(leaf * buddy_pkg::MIN_BLOCK_BYTES);
        end
      end
    end else begin
      off  = int'(rq.free_offset);
      leaf = off / buddy_pkg::MIN_BLOCK_BYTES;
      if ((off % buddy_pkg::MIN_BLOCK_BYTES) != 0 || leaf >= (1 << top) ||
          !blk_start[leaf]) begin
        r.status = buddy_pkg::ST_BAD;
      end else begin
        lvl = int'(blk_level[leaf]);
        if (lvl > top) lvl = top;
        pos             = leaf >> lvl;
        blk_start[leaf] = 1'b0;
        blk_level[leaf] = '0;
        // Merge upward while the buddy is free.
        while (lvl < top && free_mark[node_at(lvl, pos ^ 1)]) begin
          free_mark[node_at(lvl, pos ^ 1)] = 1'b0;
          pos = pos >> 1;
          lvl++;
        end
        free_mark[node_at(lvl, pos)] = 1'b1;
        k = -1;
        foreach (live_offs[i]) if (live_offs[i] == off) k = i;
        if (k >= 0) live_offs.delete(k);
      end
    end
    return r;
  endfunction

  task automatic add_req(buddy_pkg::buddy_op_e op, int size, int off);
    work_item_t it;
    it.kind              = K_REQ;
    it.req.op            = op;
    it.req.size_bytes    = buddy_pkg::SIZE_W'(size);
    it.req.free_offset   = buddy_pkg::OFF_W'(off);
    it.cfg               = '0;
    work_q.push_back(it);
  endtask

  task automatic add_ctl(work_kind_e kind, logic [buddy_pkg::LVL_W-1:0] v);
    work_item_t it;
    it.kind = kind;
    it.req  = '0;
    it.cfg  = v;
    work_q.push_back(it);
  endtask

  // Driver: pop work items, hold start until the transfer, write the pool
  // register only once the block has gone quiet.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic                  go_nxt;
    logic                  we_nxt;
    logic                  quiet;
    buddy_pkg::buddy_req_t req_nxt;
    work_item_t            it;
    int                    off;
    if (!rst_ni) begin
      start       <= 1'b0;
      req_i       <= '0;
      cfg_we_i    <= 1'b0;
      cfg_wdata_i <= buddy_pkg::POOL_RESET;
      hold_cnt    <= 0;
      calm_cnt    <= 0;
    end else begin
      go_nxt  = 1'b0;
      we_nxt  = 1'b0;
      req_nxt = buddy_pkg::buddy_req_t'(REQ_W'($urandom));
      // Predict at the transfer so the model sees items in block order.
      if (start && !busy) begin
        rsp_pending.push_back(buddy_serve(req_i));
        n_sent++;
      end
      // Skip random idling over one long stretch of items.
      quiet = (n_sent >= 300 && n_sent < 450);
      if (start && busy) begin
        go_nxt  = 1'b1;
        req_nxt = req_i;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
      end else if (work_q.size() != 0) begin
        it = work_q[0];
        case (it.kind)
          K_CFG: begin
            // Nothing may be in flight, including a transfer at this edge.
            if (calm_cnt >= 8 && rsp_pending.size() == 0) begin
              we_nxt = 1'b1;
              cfg_wdata_i <= it.cfg;
              pool_load(it.cfg);
              void'(work_q.pop_front());
              // Give the clearing pass time to raise busy.
              hold_cnt <= 4;
            end
          end
          K_DRAIN: begin
            if (rsp_pending.size() == 0) void'(work_q.pop_front());
          end
          default: begin
            if (quiet || $urandom_range(0, 99) >= 33) begin
              if (it.kind == K_FREE_LIVE) begin
                if (live_offs.size() != 0) begin
                  off = live_offs[$urandom_range(0, live_offs.size() - 1)];
                end else begin
                  off = $urandom_range(0, 16383);
                end
                req_nxt.op          = buddy_pkg::OP_FREE;
                req_nxt.free_offset = buddy_pkg::OFF_W'(off);
              end else begin
                req_nxt = it.req;
              end
              go_nxt = 1'b1;
              void'(work_q.pop_front());
            end
          end
        endcase
      end
      calm_cnt <= (rsp_pending.size() == 0 && !busy && !start) ? calm_cnt + 1 : 0;
      start    <= go_nxt;
      req_i    <= req_nxt;
      cfg_we_i <= we_nxt;
    end
  end

  // Monitor: sample mid-cycle, away from the edge where the driver pushes.
  always @(negedge clk_i) begin : check_proc
    buddy_pkg::buddy_rsp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (rsp_pending.size() == 0) begin
        flag_mismatch($sformatf("result with nothing outstanding: status %0d offset %0d",
                                rsp_o.status, rsp_o.alloc_offset));
      end else begin
        want = rsp_pending.pop_front();
        if (rsp_o.status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", rsp_o.status, want.status));
        if (rsp_o.alloc_offset !== want.alloc_offset)
          flag_mismatch($sformatf("offset %0d, expected %0d",
                                  rsp_o.alloc_offset, want.alloc_offset));
      end
    end
  end

  initial begin : main_proc
    logic [buddy_pkg::LVL_W-1:0] phase_cfg [10];
    int               top;
    int               lvl;
    int               lo;
    int               roll;
    phase_cfg = '{4'd10, 4'd3, 4'd15, 4'd1, 4'd7, 4'd0, 4'd10, 4'd12, 4'd5, 4'd2};
    pool_load(buddy_pkg::POOL_RESET);

    // Directed: zero and oversized sizes, whole pool, pool full, bad frees,
    // splits down to the minimum block and merges back to the root.
    add_req(buddy_pkg::OP_ALLOC, 0, 0);
    add_req(buddy_pkg::OP_ALLOC, POOL_MAX_B, 16383);
    add_req(buddy_pkg::OP_ALLOC, 1, 0);
    add_req(buddy_pkg::OP_FREE, 32767, 0);
    add_req(buddy_pkg::OP_FREE, 0, 0);
    add_req(buddy_pkg::OP_ALLOC, POOL_MAX_B + 1, 0);
    add_req(buddy_pkg::OP_ALLOC, 32767, 0);
    add_req(buddy_pkg::OP_ALLOC, 1, 0);
    add_req(buddy_pkg::OP_ALLOC, buddy_pkg::MIN_BLOCK_BYTES, 0);
    add_req(buddy_pkg::OP_ALLOC, buddy_pkg::MIN_BLOCK_BYTES + 1, 0);
    add_req(buddy_pkg::OP_ALLOC, POOL_MAX_B / 2, 0);
    add_req(buddy_pkg::OP_FREE, 0, 8);
    add_req(buddy_pkg::OP_FREE, 0, 16383);
    add_req(buddy_pkg::OP_FREE, 0, 48);
    add_req(buddy_pkg::OP_FREE, 0, 16);
    add_req(buddy_pkg::OP_FREE, 0, 0);
    add_req(buddy_pkg::OP_FREE, 0, 32);
    add_req(buddy_pkg::OP_FREE, 0, POOL_MAX_B / 2);
    // Saturated pool setting, then a write that drops a live allocation.
    add_ctl(K_CFG, 4'd15);
    add_req(buddy_pkg::OP_ALLOC, POOL_MAX_B, 0);
    add_ctl(K_CFG, 4'd0);
    add_req(buddy_pkg::OP_ALLOC, buddy_pkg::MIN_BLOCK_BYTES, 0);
    add_req(buddy_pkg::OP_ALLOC, 1, 0);
    add_req(buddy_pkg::OP_ALLOC, buddy_pkg::MIN_BLOCK_BYTES + 1, 0);
    add_req(buddy_pkg::OP_FREE, 0, buddy_pkg::MIN_BLOCK_BYTES);
    add_req(buddy_pkg::OP_FREE, 0, 0);

    // Random phases, one pool setting each: mostly well-formed allocs and
    // frees of live blocks, some noise.
    foreach (phase_cfg[ph]) begin
      add_ctl(K_CFG, phase_cfg[ph]);
      top = (phase_cfg[ph] > buddy_pkg::TOP_MAX) ? int'(buddy_pkg::TOP_MAX) :
                                                    int'(phase_cfg[ph]);
      for (int n = 0; n < 93; n++) begin
        // Hold off once until every outstanding result is back.
        if (ph == 4 && n == 40) add_ctl(K_DRAIN, '0);
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          if ($urandom_range(0, 9) < 7) lvl = $urandom_range(0, (top < 3) ? top : 3);
          else lvl = $urandom_range(0, top);
          lo = (lvl == 0) ? 1 : (buddy_pkg::MIN_BLOCK_BYTES << (lvl - 1)) + 1;
          add_req(buddy_pkg::OP_ALLOC, $urandom_range(lo, buddy_pkg::MIN_BLOCK_BYTES << lvl),
                  $urandom_range(0, 16383));
        end else if (roll < 85) begin
          add_ctl(K_FREE_LIVE, '0);
        end else if (roll < 92) begin
          add_req(buddy_pkg::OP_ALLOC, $urandom_range(0, 32767), $urandom_range(0, 16383));
        end else if (roll[0]) begin
          add_req(buddy_pkg::OP_FREE, $urandom_range(0, 32767),
                  $urandom_range(0, (1 << top) - 1) * buddy_pkg::MIN_BLOCK_BYTES);
        end else begin
          add_req(buddy_pkg::OP_FREE, $urandom_range(0, 32767), $urandom_range(0, 16383));
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all work issued, every transfer answered, then let it settle.
    do @(negedge clk_i);
    while (work_q.size() != 0 || rsp_pending.size() != 0 || start);
    repeat (64) @(posedge clk_i);
    if (rsp_pending.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", rsp_pending.size()));
    if (n_bad == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
